// ===== sv/urr_pkg.sv =====
// ----------------------------------------------------------------------------
// urr_pkg
// shared widths and the per-stage record of the range reducer pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package urr_pkg;
  localparam int unsigned WordW = 64;

  typedef struct packed {
    logic [WordW-1:0] lower;
    logic [WordW-1:0] draw;
    logic [WordW-1:0] span;
    logic [WordW-1:0] rem_max;
    logic [WordW-1:0] rem_draw;
    logic             bad;
    logic             full;
  } stage_t;
endpackage
`default_nettype wire

// ===== sv/urr_req_if.sv =====
// ----------------------------------------------------------------------------
// urr_req_if
// request channel: bounds and one random draw
// ----------------------------------------------------------------------------
`default_nettype none
interface urr_req_if;
  logic                           valid;
  logic                           ready;
  logic signed [urr_pkg::WordW-1:0] lower_bound;
  logic signed [urr_pkg::WordW-1:0] upper_bound;
  logic        [urr_pkg::WordW-1:0] random_draw;
  modport source (output valid, lower_bound, upper_bound, random_draw, input ready);
  modport sink   (input valid, lower_bound, upper_bound, random_draw, output ready);
endinterface
`default_nettype wire

// ===== sv/urr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// urr_rsp_if
// response channel: reduced value and status flags
// ----------------------------------------------------------------------------
`default_nettype none
interface urr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [urr_pkg::WordW-1:0] result_value;
  logic                             accepted;
  logic                             bad_bounds;
  modport source (output valid, result_value, accepted, bad_bounds, input ready);
  modport sink   (input valid, result_value, accepted, bad_bounds, output ready);
endinterface
`default_nettype wire

// ===== sv/urr_prep.sv =====
// ----------------------------------------------------------------------------
// urr_prep
// first stage: bound check and span = upper - lower + 1
// ----------------------------------------------------------------------------
`default_nettype none
module urr_prep (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      v_in,
  input  wire logic [urr_pkg::WordW-1:0] lower,
  input  wire logic [urr_pkg::WordW-1:0] upper,
  input  wire logic [urr_pkg::WordW-1:0] draw,
  output logic                           v_out,
  output urr_pkg::stage_t                d_out
);
  urr_pkg::stage_t d_next;

  always_comb begin
    d_next.lower    = lower;
    d_next.draw     = draw;
    d_next.span     = upper - lower + urr_pkg::WordW'(1);
    d_next.rem_max  = '0;
    d_next.rem_draw = '0;
    d_next.bad      = $signed(upper) < $signed(lower);
    d_next.full     = (d_next.span == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/urr_div_step.sv =====
// ----------------------------------------------------------------------------
// urr_div_step
// one restoring-division bit for both remainders (all-ones and draw by span)
// ----------------------------------------------------------------------------
`default_nettype none
module urr_div_step #(
  parameter int unsigned BitIdx = 63
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire urr_pkg::stage_t d_in,
  output logic                 v_out,
  output urr_pkg::stage_t      d_out
);
  localparam int unsigned W = urr_pkg::WordW;

  logic [W:0]      t_max, t_draw, dvs;
  urr_pkg::stage_t d_next;

  always_comb begin
    dvs    = {1'b0, d_in.span};
    t_max  = {d_in.rem_max, 1'b1};
    t_draw = {d_in.rem_draw, d_in.draw[BitIdx]};
    d_next = d_in;
    // subtract when the partial remainder reaches the divisor
    d_next.rem_max  = (t_max >= dvs)  ? W'(t_max - dvs)  : t_max[W-1:0];
    d_next.rem_draw = (t_draw >= dvs) ? W'(t_draw - dvs) : t_draw[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/urr_finish.sv =====
// ----------------------------------------------------------------------------
// urr_finish
// last stage: rejection test against the limit and offset by lower bound
// ----------------------------------------------------------------------------
`default_nettype none
module urr_finish (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      v_in,
  input  wire urr_pkg::stage_t           d_in,
  output logic                           v_out,
  output logic [urr_pkg::WordW-1:0]      value,
  output logic                           ok,
  output logic                           bad
);
  logic [urr_pkg::WordW-1:0] limit;
  logic [urr_pkg::WordW-1:0] value_next;
  logic                      ok_next;

  always_comb begin
    limit      = '1 - d_in.rem_max;
    value_next = '0;
    ok_next    = 1'b0;
    if (d_in.bad) begin
      ok_next = 1'b0;
    end else if (d_in.full) begin
      value_next = d_in.draw;
      ok_next    = 1'b1;
    end else if (d_in.draw < limit) begin
      value_next = d_in.lower + d_in.rem_draw;
      ok_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
      ok    <= ok_next;
      bad   <= d_in.bad;
    end
  end
endmodule
`default_nettype wire

// ===== sv/unbiased_range_reducer.sv =====
// ----------------------------------------------------------------------------
// unbiased_range_reducer
// maps a 64-bit random draw onto [lower, upper] by rejection sampling
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   lower_bound, upper_bound, random_draw
//  rsp      out  result_value, accepted, bad_bounds
//
//  one item per cycle while the output is not stalled; stages: prep, 64 division bits, finish
//  the two remainders come from a 64-stage restoring divider, one bit a stage
//  the whole pipe advances when the output register is empty or being taken
//  a stall freezes every stage in place; reset clears only the valid bits
// ----------------------------------------------------------------------------
`default_nettype none
module unbiased_range_reducer (
  input  wire logic clk,
  input  wire logic rst,
  urr_req_if.sink   req,
  urr_rsp_if.source rsp
);
  localparam int unsigned W = urr_pkg::WordW;

  // global advance: output slot free or drained this cycle
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // stage chain: index 0 is prep output, index W is last division bit
  logic            v_pipe [W+1];
  urr_pkg::stage_t d_pipe [W+1];

  urr_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .v_in  (req.valid),
    .lower (req.lower_bound),
    .upper (req.upper_bound),
    .draw  (req.random_draw),
    .v_out (v_pipe[0]),
    .d_out (d_pipe[0])
  );

  // dividend bits walk from msb down, one per stage
  for (genvar g = 0; g < W; g++) begin : g_div
    urr_div_step #(.BitIdx(W-1-g)) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .v_in  (v_pipe[g]),
      .d_in  (d_pipe[g]),
      .v_out (v_pipe[g+1]),
      .d_out (d_pipe[g+1])
    );
  end

  logic [W-1:0] value;

  urr_finish u_finish (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .v_in  (v_pipe[W]),
    .d_in  (d_pipe[W]),
    .v_out (rsp.valid),
    .value (value),
    .ok    (rsp.accepted),
    .bad   (rsp.bad_bounds)
  );

  assign rsp.result_value = $signed(value);
endmodule
`default_nettype wire

// ===== dv/tb_req_if_unused.sv =====
// ----------------------------------------------------------------------------
// tb_bounds_pkg
// latency and timeout constants for the range reducer testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package tb_bounds_pkg;
  localparam int unsigned LatencyCycles = 66;
  localparam int unsigned CycleLimit    = 400000;
endpackage

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks unbiased_range_reducer against an in-house predictor of the
// rejection sampling rule: directed corner bounds, then random items under
// three idling patterns on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  typedef logic [urr_pkg::WordW-1:0] word_t;

  // one expected response item
  typedef struct packed {
    word_t value;
    logic  ok;
    logic  bad;
  } reduced_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  urr_req_if req ();
  urr_rsp_if rsp ();

  unbiased_range_reducer dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  reduced_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned take_idle_pct  = 0;
  longint unsigned cycle_count = 0;

  // predictor: width wraps to zero on the full range, limit drops the top
  // (max mod width)+1 draws so every residue has equal weight
  function automatic reduced_t reduce_draw(word_t lo, word_t hi, word_t draw);
    reduced_t r;
    word_t    span;
    word_t    limit;
    r = '0;
    if ($signed(hi) < $signed(lo)) begin
      r.bad = 1'b1;
    end else begin
      span = hi - lo + word_t'(1);
      if (span == '0) begin
        r.value = draw;
        r.ok    = 1'b1;
      end else begin
        limit = {urr_pkg::WordW{1'b1}} - ({urr_pkg::WordW{1'b1}} % span);
        if (draw < limit) begin
          r.value = lo + (draw % span);
          r.ok    = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > tb_bounds_pkg::CycleLimit) begin
      $display("unbiased_range_reducer verification failed");
      $finish;
    end
  end

  // receiver side: random stalls on ready
  initial rsp.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // response checker, compares each taken item against the oldest expectation
  always @(posedge clk) begin
    reduced_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", word_t'(rsp.result_value), '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.accepted !== want.ok)
          report_mismatch("accepted", word_t'(rsp.accepted), word_t'(want.ok));
        if (rsp.bad_bounds !== want.bad)
          report_mismatch("bad_bounds", word_t'(rsp.bad_bounds), word_t'(want.bad));
        if (rsp.result_value !== want.value)
          report_mismatch("result_value", word_t'(rsp.result_value), want.value);
      end
    end
  end

  initial begin
    req.valid       = 1'b0;
    req.lower_bound = '0;
    req.upper_bound = '0;
    req.random_draw = '0;
  end

  // send one item, holding valid until accepted; idle gaps drawn per item
  task automatic send_item(word_t lo, word_t hi, word_t draw);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.lower_bound <= lo;
    req.upper_bound <= hi;
    req.random_draw <= draw;
    pending_results.push_back(reduce_draw(lo, hi, draw));
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  localparam word_t MinS = {1'b1, {(urr_pkg::WordW-1){1'b0}}};
  localparam word_t MaxS = {1'b0, {(urr_pkg::WordW-1){1'b1}}};
  localparam word_t AllOnes = {urr_pkg::WordW{1'b1}};

  task automatic test_directed();
    send_item(MinS, MaxS, AllOnes);           // full range passes draw through
    send_item(MinS, MaxS, '0);
    send_item(word_t'(5), word_t'(3), rand_word());   // reversed bounds
    send_item(MaxS, MinS, '0);
    send_item(word_t'(7), word_t'(7), AllOnes);       // width one, rejected
    send_item(word_t'(7), word_t'(7), AllOnes - word_t'(1));
    send_item('0, word_t'(15), AllOnes);              // power-of-two width
    send_item('0, word_t'(15), AllOnes - word_t'(16));
    send_item('0, word_t'(15), AllOnes - word_t'(15));
    send_item(MinS, MinS, '0);
    send_item(MaxS, MaxS, word_t'(123));
    send_item('0, MaxS, AllOnes - word_t'(1));
    send_item(MinS, word_t'(-1), rand_word());
    send_item(word_t'(-10), word_t'(10), AllOnes - word_t'(5));  // odd width, near limit
    send_item(word_t'(-10), word_t'(10), word_t'(40));
    send_item(MinS + word_t'(1), MaxS, AllOnes - word_t'(1));    // width max
    send_item(MinS + word_t'(1), MaxS, AllOnes);
  endtask

  // random bounds of mixed widths, including reversed and near-full ranges;
  // draws land near the limit often enough to hit rejections
  task automatic test_random(int unsigned count);
    word_t lo, hi, draw, span, limit;
    for (int unsigned i = 0; i < count; i++) begin
      lo = rand_word();
      case ($urandom_range(5))
        0: hi = rand_word();
        1: hi = lo + word_t'($urandom_range(64));
        2: hi = lo + (word_t'(1) << $urandom_range(urr_pkg::WordW-1)) - word_t'(1);
        3: hi = lo + (rand_word() >> $urandom_range(urr_pkg::WordW-1));
        4: hi = lo - word_t'($urandom_range(8));
        default: begin
          lo = MinS + word_t'($urandom_range(3));
          hi = MaxS - word_t'($urandom_range(3));
        end
      endcase
      draw = rand_word();
      if ($urandom_range(3) == 0) begin
        span  = hi - lo + word_t'(1);
        limit = (span == '0) ? AllOnes : AllOnes - (AllOnes % span);
        draw  = limit + word_t'($urandom_range(4)) - word_t'(2);
      end
      send_item(lo, hi, draw);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 20; take_idle_pct = 55;
    test_random(250);
    send_idle_pct = 55; take_idle_pct = 20;
    test_random(250);
    send_idle_pct = 0; take_idle_pct = 0;
    test_random(250);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (tb_bounds_pkg::LatencyCycles + 10) @(posedge clk);
    if (mismatch_count == 0)
      $display("unbiased_range_reducer verification clean");
    else
      $display("unbiased_range_reducer verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/urr_pkg.sv
sv/urr_req_if.sv
sv/urr_rsp_if.sv
sv/urr_prep.sv
sv/urr_div_step.sv
sv/urr_finish.sv
sv/unbiased_range_reducer.sv
dv/tb_req_if_unused.sv
dv/testbench.sv
